// ----- hw/rtl/ring_insertion_point_search_top_defines.svh -----
// Assertion macros shared by the checker of the ring insertion-point search block.
`ifndef RING_INSERTION_POINT_SEARCH_TOP_DEFINES_SVH
`define RING_INSERTION_POINT_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and cleared while rst_n is low.
`define RIPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and cleared while rst_n is low.
`define RIPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/rips_pkg.sv -----
// Package with the constants, codes and types of the ring insertion-point search block.
package rips_pkg;

  localparam int CAPACITY = 512;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 2;
  localparam int POS_W    = 9;
  localparam int PATH_W   = 2;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int STEP_W   = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  localparam logic [PATH_W-1:0] PATH_RANGE = 2'd0;
  localparam logic [PATH_W-1:0] PATH_GAP   = 2'd1;
  localparam logic [PATH_W-1:0] PATH_NOGAP = 2'd2;
  localparam logic [PATH_W-1:0] PATH_EMPTY = 2'd3;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MINMAX,
    ST_CHECK,
    ST_GAP,
    ST_DONE
  } scan_state_t;

  typedef struct packed {
    logic               rotate;
    logic               append;
    logic [COUNT_W-1:0] tail;
    logic [COUNT_W-1:0] wrap;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/rips_cell.sv -----
// One storage cell of the entry ring: loads an appended word or takes its neighbor's word.
module rips_cell (
  input  logic                        clk,
  input  rips_pkg::cell_ctl_t         ctl,
  input  logic [rips_pkg::IDX_W-1:0]  my_idx,
  input  rips_pkg::word_t             app_data,
  input  rips_pkg::word_t             neighbor,
  input  rips_pkg::word_t             head,
  output rips_pkg::word_t             data
);
  import rips_pkg::*;

  word_t data_r;
  word_t data_nxt;
  logic  at_tail;
  logic  at_wrap;

  assign at_tail = (COUNT_W'(my_idx) == ctl.tail);
  assign at_wrap = (COUNT_W'(my_idx) == ctl.wrap);

  always_comb begin
    data_nxt = data_r;
    if (ctl.append && at_tail) begin
      data_nxt = app_data;
    end else if (ctl.rotate) begin
      data_nxt = at_wrap ? head : neighbor;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- hw/rtl/rips_scan.sv -----
// Query sequencer: rotates the ring for min and max, then for the first gap if in range.
module rips_scan (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  rips_pkg::word_t               key,
  input  logic [rips_pkg::COUNT_W-1:0]  count,
  input  rips_pkg::word_t               head,
  input  logic                          res_take,
  output logic                          rotate,
  output logic                          busy,
  output logic                          res_valid,
  output logic [rips_pkg::POS_W-1:0]    res_pos,
  output logic [rips_pkg::PATH_W-1:0]   res_path
);
  import rips_pkg::*;

  scan_state_t         state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  word_t               key_r, key_nxt;
  word_t               lo_r, lo_nxt;
  word_t               hi_r, hi_nxt;
  word_t               prev_r, prev_nxt;
  logic [POS_W-1:0]    min_at_r, min_at_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [PATH_W-1:0]   path_r, path_nxt;
  logic                found_r, found_nxt;
  logic                last_step;
  logic                out_of_range;
  logic                hit;

  assign last_step    = (step_r == STEP_W'(COUNT_W'(count - COUNT_W'(1))));
  assign out_of_range = (key_r > hi_r) || (key_r < lo_r);
  assign hit          = !found_r && (prev_r < key_r) && (key_r < head);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (count == '0) ? ST_DONE : ST_MINMAX;
        end
      end
      ST_MINMAX: begin
        if (last_step) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = out_of_range ? ST_DONE : ST_GAP;
      end
      ST_GAP: begin
        if (last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    rotate    = 1'b0;
    busy      = 1'b1;
    res_valid = 1'b0;
    unique case (state_r)
      ST_IDLE:   busy = 1'b0;
      ST_MINMAX: rotate = 1'b1;
      ST_CHECK:  rotate = 1'b0;
      ST_GAP:    rotate = 1'b1;
      ST_DONE:   res_valid = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  always_comb begin
    step_nxt   = step_r;
    key_nxt    = key_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    prev_nxt   = prev_r;
    min_at_nxt = min_at_r;
    pos_nxt    = pos_r;
    path_nxt   = path_r;
    found_nxt  = found_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          key_nxt  = key;
          step_nxt = '0;
          pos_nxt  = '0;
          path_nxt = PATH_EMPTY;
        end
      end
      ST_MINMAX: begin
        if (step_r == '0) begin
          lo_nxt     = head;
          hi_nxt     = head;
          min_at_nxt = '0;
        end else begin
          if (head < lo_r) begin
            lo_nxt     = head;
            min_at_nxt = step_r[POS_W-1:0];
          end
          if (head > hi_r) begin
            hi_nxt = head;
          end
        end
        prev_nxt = head;
        step_nxt = last_step ? '0 : step_r + STEP_W'(1);
      end
      ST_CHECK: begin
        found_nxt = 1'b0;
        step_nxt  = '0;
        if (out_of_range) begin
          pos_nxt  = min_at_r;
          path_nxt = PATH_RANGE;
        end
      end
      ST_GAP: begin
        if (hit) begin
          found_nxt = 1'b1;
          pos_nxt   = step_r[POS_W-1:0];
        end
        if (last_step) begin
          if (found_r || hit) begin
            path_nxt = PATH_GAP;
          end else begin
            pos_nxt  = '0;
            path_nxt = PATH_NOGAP;
          end
        end
        prev_nxt = head;
        step_nxt = last_step ? '0 : step_r + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    prev_r   <= prev_nxt;
    min_at_r <= min_at_nxt;
    pos_r    <= pos_nxt;
    path_r   <= path_nxt;
  end

  assign res_pos  = pos_r;
  assign res_path = path_r;

endmodule

// ----- hw/rtl/ring_insertion_point_search_top.sv -----
// Clear and append words do not stall the input; the block is ready again on the next cycle.
// A query on n entries rotates the ring once for minimum and maximum, checks the key's range,
// and for a key within that range rotates it again for the first gap; an empty ring goes straight
// to the result. A query holds the input until its result enters the output register.
// The rate is set by the ring of cells, which rotates one entry past the compare unit a cycle.
// Synchronous active-low reset empties the ring and clears out_valid; entries are not cleared.
module ring_insertion_point_search_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rips_pkg::CMD_W-1:0]    in_cmd,
  input  logic signed [rips_pkg::DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rips_pkg::POS_W-1:0]    out_position,
  output logic [rips_pkg::PATH_W-1:0]   out_path
);
  import rips_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]   out_position_r, out_position_nxt;
  logic [PATH_W-1:0]  out_path_r, out_path_nxt;

  logic               in_accept;
  logic               start;
  logic               append_en;
  logic               rotate;
  logic               busy;
  logic               res_valid;
  logic               res_take;
  logic [POS_W-1:0]   res_pos;
  logic [PATH_W-1:0]  res_path;
  cell_ctl_t          ctl;
  word_t              cell_q [CAPACITY];

  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign start     = in_accept && (in_cmd == CMD_QUERY);
  assign append_en = in_accept && (in_cmd == CMD_APPEND) && (count_r < COUNT_W'(CAPACITY));

  always_comb begin
    count_nxt = count_r;
    if (in_accept && (in_cmd == CMD_CLEAR)) begin
      count_nxt = '0;
    end else if (append_en) begin
      count_nxt = count_r + COUNT_W'(1);
    end
  end

  always_comb begin
    ctl.rotate = rotate;
    ctl.append = append_en;
    ctl.tail   = count_r;
    ctl.wrap   = count_r - COUNT_W'(1);
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rips_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .my_idx   (IDX_W'(i)),
      .app_data (in_value),
      .neighbor (cell_q[(i + 1) % CAPACITY]),
      .head     (cell_q[0]),
      .data     (cell_q[i])
    );
  end

  rips_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .key       (in_value),
    .count     (count_r),
    .head      (cell_q[0]),
    .res_take  (res_take),
    .rotate    (rotate),
    .busy      (busy),
    .res_valid (res_valid),
    .res_pos   (res_pos),
    .res_path  (res_path)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_position_nxt = out_position_r;
    out_path_nxt     = out_path_r;
    if (res_take) begin
      out_valid_nxt    = 1'b1;
      out_position_nxt = res_pos;
      out_path_nxt     = res_path;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_position_r <= out_position_nxt;
    out_path_r     <= out_path_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_path     = out_path_r;

endmodule

// ----- hw/rtl/rips_checker.sv -----
// Port-level checker for the ring insertion-point search block, bound to its top level.
`include "ring_insertion_point_search_top_defines.svh"

module rips_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [rips_pkg::CMD_W-1:0]    in_cmd,
  input logic signed [rips_pkg::DATA_W-1:0] in_value,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rips_pkg::POS_W-1:0]    out_position,
  input logic [rips_pkg::PATH_W-1:0]   out_path
);
  import rips_pkg::*;

  `RIPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_position) && $stable(out_path), "Stalled result word changed.")
  `RIPS_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (in_cmd == CMD_QUERY), in_stall, "Input not stalled while a query is searched.")
  `RIPS_ASSERT_NEXT(a_update_ready, in_valid && !in_stall && (in_cmd != CMD_QUERY), !in_stall, "Clear or append word left the block stalled.")
  `RIPS_ASSERT_NOW(a_empty_zero, out_valid && (out_path == PATH_EMPTY), out_position == '0, "Empty ring gave a nonzero position.")
  `RIPS_ASSERT_NOW(a_nogap_zero, out_valid && (out_path == PATH_NOGAP), out_position == '0, "No-gap result gave a nonzero position.")

endmodule

bind ring_insertion_point_search_top rips_checker u_rips_checker (.*);

// ----- sim/ring_insertion_point_search_top_tb.sv -----
// Self-checking testbench for the ring insertion-point search block, with a built-in ring predictor.
module ring_insertion_point_search_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rips_pkg::*;

  localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
  localparam word_t WORD_MIN = 32'sh8000_0000;
  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam int RAND_ITEMS = 400;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [PATH_W-1:0] path;
  } slot_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    word_t            value;
    logic             fixed;
    slot_t            typed;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [24] = '{
    '{CMD_QUERY,   32'sd0,          1'b1, '{9'd0, PATH_EMPTY}},
    '{CMD_IGNORED, 32'shFFFF_FFFF,  1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   WORD_MIN,        1'b1, '{9'd0, PATH_EMPTY}},
    '{CMD_APPEND,  32'sd5,          1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   32'sd5,          1'b1, '{9'd0, PATH_NOGAP}},
    '{CMD_QUERY,   32'sd6,          1'b1, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   WORD_MIN,        1'b1, '{9'd0, PATH_RANGE}},
    '{CMD_CLEAR,   32'sd0,          1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_APPEND,  32'sd10,         1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_APPEND,  32'sd20,         1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_APPEND,  -32'sd30,        1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   32'sd15,         1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   32'sd0,          1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   32'sd25,         1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   32'sd20,         1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   WORD_MAX,        1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_CLEAR,   32'sh5555_AAAA,  1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_APPEND,  WORD_MAX,        1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_APPEND,  WORD_MIN,        1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   32'sd0,          1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   WORD_MIN,        1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   32'shFFFF_FFFF,  1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_CLEAR,   32'shAAAA_5555,  1'b0, '{9'd0, PATH_RANGE}},
    '{CMD_QUERY,   32'sd7,          1'b1, '{9'd0, PATH_EMPTY}}
  };

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CMD_W-1:0]  in_cmd;
  word_t             in_value;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [POS_W-1:0]  out_position;
  logic [PATH_W-1:0] out_path;

  word_t   ring_store [CAPACITY];
  int      ring_count;
  slot_t   pending_slots [$];
  longint  sorted_vals [64];
  int      fault_count = 0;
  int      src_idle_pct = 29;
  int      snk_stall_pct = 51;
  bit      hold_go = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;

  ring_insertion_point_search_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_position (out_position),
    .out_path     (out_path)
  );

  always #4 clk = ~clk;

  function automatic slot_t locate_slot(input word_t key);
    slot_t res;
    word_t lo;
    word_t hi;
    word_t prior;
    int    lo_at;
    res.pos = '0;
    res.path = PATH_NOGAP;
    lo_at = 0;
    if (ring_count == 0) begin
      res.path = PATH_EMPTY;
      return res;
    end
    lo = ring_store[0];
    hi = ring_store[0];
    for (int i = 1; i < ring_count; i++) begin
      if (ring_store[i] < lo) begin
        lo = ring_store[i];
        lo_at = i;
      end
      if (ring_store[i] > hi) begin
        hi = ring_store[i];
      end
    end
    if (key > hi || key < lo) begin
      res.pos = POS_W'(lo_at);
      res.path = PATH_RANGE;
      return res;
    end
    for (int i = 0; i < ring_count; i++) begin
      prior = ring_store[(i == 0) ? ring_count - 1 : i - 1];
      if (prior < key && key < ring_store[i]) begin
        res.pos = POS_W'(i);
        res.path = PATH_GAP;
        return res;
      end
    end
    return res;
  endfunction

  function automatic bit apply_word(input logic [CMD_W-1:0] c, input word_t v,
                                    output slot_t res);
    res = '0;
    case (c)
      CMD_CLEAR: begin
        ring_count = 0;
      end
      CMD_APPEND: begin
        if (ring_count < CAPACITY) begin
          ring_store[ring_count] = v;
          ring_count++;
        end
      end
      CMD_QUERY: begin
        res = locate_slot(v);
        return 1'b1;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  function automatic word_t clamp_word(input longint x);
    if (x > longint'(WORD_MAX)) begin
      return WORD_MAX;
    end
    if (x < longint'(WORD_MIN)) begin
      return WORD_MIN;
    end
    return word_t'(x);
  endfunction

  function automatic word_t pick_key(input int n);
    int     j;
    int     offs;
    longint k;
    j = $urandom_range(0, n - 1);
    offs = $urandom_range(0, 1000);
    case ($urandom_range(0, 5))
      0: k = sorted_vals[j];
      1: k = sorted_vals[j] + 1;
      2: k = sorted_vals[n-1] + 1 + offs;
      3: k = sorted_vals[0] - 1 - offs;
      4: k = $signed($urandom());
      default: k = $urandom_range(0, 1) ? longint'(WORD_MAX) : longint'(WORD_MIN);
    endcase
    return clamp_word(k);
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] c, input word_t v,
                           input bit fixed = 1'b0, input slot_t typed = '0);
    slot_t res;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= c;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (apply_word(c, v, res)) begin
      pending_slots.push_back(fixed ? typed : res);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    slot_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_slots.size() == 0) begin
        $display("%0t: unexpected result, position %0d path %0d", $time,
                 out_position, out_path);
        fault_count++;
      end else begin
        want = pending_slots.pop_front();
        if (out_position !== want.pos) begin
          $display("%0t: position expected %0d, actual %0d", $time, want.pos,
                   out_position);
          fault_count++;
        end
        if (out_path !== want.path) begin
          $display("%0t: path expected %0d, actual %0d", $time, want.path, out_path);
          fault_count++;
        end
      end
    end
  end

  initial begin
    int               rand_items;
    int               run_len;
    int               n_req;
    int               rot;
    int               step;
    int               reps;
    bit               tight;
    bit               pressure_done;
    longint           acc;
    logic [CMD_W-1:0] c;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_CLEAR;
    in_value = '0;
    ring_count = 0;
    rand_items = 0;
    pressure_done = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < 24; r++) begin
      send_word(DIR_ROWS[r].cmd, DIR_ROWS[r].value, DIR_ROWS[r].fixed, DIR_ROWS[r].typed);
    end

    // Fill the ring past capacity with a rotated ascending run.
    rot = $urandom_range(256, CAPACITY - 1);
    send_word(CMD_CLEAR, $urandom());
    for (int i = 0; i < CAPACITY + 8; i++) begin
      send_word(CMD_APPEND, word_t'(((i + CAPACITY - rot) % CAPACITY) * 8 - 2048));
    end
    send_word(CMD_QUERY, 32'sd100000);
    send_word(CMD_QUERY, 32'sd3);
    send_word(CMD_QUERY, 32'sd0);
    send_word(CMD_QUERY, WORD_MIN);

    while (rand_items < RAND_ITEMS) begin
      if (rand_items < RAND_ITEMS / 3) begin
        src_idle_pct = 29;
        snk_stall_pct = 51;
      end else if (rand_items < 2 * RAND_ITEMS / 3) begin
        src_idle_pct = 51;
        snk_stall_pct = 29;
      end else begin
        src_idle_pct = 0;
        snk_stall_pct = 0;
        if (!pressure_done) begin
          pressure_done = 1'b1;
          hold_go <= 1'b1;
          send_word(CMD_CLEAR, $urandom());
          rand_items++;
          repeat (4) begin
            send_word(CMD_QUERY, $urandom());
            rand_items++;
          end
        end
      end

      case ($urandom_range(0, 9))
        7: begin
          reps = $urandom_range(1, 6);
          repeat (reps) begin
            c = CMD_W'($urandom_range(0, 3));
            send_word(c, $urandom());
            if (c != CMD_IGNORED) begin
              rand_items++;
            end
          end
        end
        8, 9: begin
          tight = 1'($urandom_range(0, 1));
          reps = $urandom_range(1, 6);
          repeat (reps) begin
            send_word(CMD_APPEND, tight ? word_t'($urandom_range(0, 6)) - 32'sd3
                                        : word_t'($urandom()));
            rand_items++;
          end
          reps = $urandom_range(1, 2);
          repeat (reps) begin
            send_word(CMD_QUERY, tight ? word_t'($urandom_range(0, 8)) - 32'sd4
                                       : word_t'($urandom()));
            rand_items++;
          end
        end
        default: begin
          n_req = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
          tight = 1'($urandom_range(0, 1));
          acc = $signed($urandom());
          run_len = 0;
          for (int i = 0; i < n_req; i++) begin
            if (acc > longint'(WORD_MAX)) begin
              break;
            end
            sorted_vals[i] = acc;
            run_len = i + 1;
            step = tight ? $urandom_range(0, 3) : $urandom_range(0, 1 << 26);
            acc = acc + step;
          end
          rot = $urandom_range(0, run_len - 1);
          send_word(CMD_CLEAR, $urandom());
          rand_items++;
          for (int i = 0; i < run_len; i++) begin
            send_word(CMD_APPEND, clamp_word(sorted_vals[(i + rot) % run_len]));
            rand_items++;
          end
          reps = $urandom_range(1, 4);
          repeat (reps) begin
            send_word(CMD_QUERY, pick_key(run_len));
            rand_items++;
          end
        end
      endcase
    end
    in_valid <= 1'b0;

    while (pending_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("ring_insertion_point_search_top_tb: done, clean");
    end else begin
      $display("ring_insertion_point_search_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("ring_insertion_point_search_top_tb: done, errors");
    $finish;
  end

endmodule
